// ----- rtl/i2cmbe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
package i2cmbe_pkg;

  // Default width of the hold tick counter
  localparam int TICK_COUNT_WIDTH_DEF = 8;

  // Command operation codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_WAIT  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_LONG_HOLD   = 2'd0;
  localparam logic [1:0] CFG_BIT_HOLD    = 2'd1;
  localparam logic [1:0] CFG_SHORT_HOLD  = 2'd2;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd3;

  // Configuration reset values
  localparam logic [7:0] LONG_HOLD_RST   = 8'd4;
  localparam logic [7:0] BIT_HOLD_RST    = 8'd2;
  localparam logic [7:0] SHORT_HOLD_RST  = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_HIGH,
    PH_ST_LOW,
    PH_SP_LOW,
    PH_SP_HIGH,
    PH_WR_SETUP,
    PH_WR_HIGH,
    PH_WR_LOW,
    PH_WA_REL,
    PH_WA_POLL,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_AK_LOW,
    PH_AK_HIGH
  } phase_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } res_t;

endpackage

// ----- rtl/i2c_master_bit_engine.sv -----
// I2C master bit engine: per-tick command sequencer with skid-buffered result output.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per timing tick, carrying
//   cmd_valid, op, tx_byte, send_ack and the sampled SDA level sda_in. A
//   command is taken only while the engine is idle; otherwise it is ignored.
//   Output channel (out_valid / out_stall): exactly one result item per input
//   item, with the SCL/SDA levels, SDA drive enable, busy, done pulse, the
//   last received byte and the last no-ack outcome.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no item is in flight.
// Timing:
//   One item per clock sustained while in_stall is low. The state update for
//   an item is a single pass from the phase/counter registers into the result
//   register, which captures the result on acceptance (the skid slot if stalled).
//   The output has a one-entry skid stage: a stalled result does not stop the
//   next item; in_stall rises only when both output slots are full.
// Reset: rst (sync, active high) returns the engine to idle with SCL and SDA
//   high and driven, clears counters and flags, reloads register defaults
//   and empties the output slots.
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd_valid,
  input  logic [2:0] op,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       sda_drive_enable,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       no_ack,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int HW   = TICK_COUNT_WIDTH;
  localparam int ExtW = (HW > 8) ? HW : 8;
  localparam logic [ExtW-1:0] HoldMax = ExtW'({HW{1'b1}});

  // Register value to hold count: zero counts as one tick, saturate at counter
  function automatic logic [HW-1:0] hold_of(input logic [7:0] ticks);
    logic [7:0]      tm1;
    logic [ExtW-1:0] ext;
    tm1 = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
    ext = ExtW'(tm1);
    if (ext > HoldMax) begin
      ext = HoldMax;
    end
    return ext[HW-1:0];
  endfunction

  // Configuration registers
  logic [7:0] long_hold_ticks;
  logic [7:0] bit_hold_ticks;
  logic [7:0] short_hold_ticks;
  logic [7:0] ack_timeout_ticks;

  // Engine state
  phase_t          phase, phase_next;
  logic [HW-1:0]   hold_count, hold_count_next;
  logic [3:0]      bit_count, bit_count_next;
  logic [7:0]      shift_reg, shift_reg_next;
  logic [7:0]      poll_count, poll_count_next;
  logic            scl_reg, scl_reg_next;
  logic            sda_reg, sda_reg_next;
  logic            drive_reg, drive_reg_next;
  logic            ack_flag, ack_flag_next;
  logic            ack_choice, ack_choice_next;
  logic [7:0]      rx_reg, rx_reg_next;

  // Output slots
  res_t out_data;
  res_t skid_data;
  logic skid_valid;
  res_t res;

  logic [HW-1:0] long_hold, bit_hold, short_hold;
  logic          accept;
  logic          in_idle;
  logic          start_cmd;
  logic          adv;
  logic [3:0]    bit_inc;
  logic          poll_expired;
  logic          out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign out_fire  = out_valid && !out_stall;

  assign long_hold  = hold_of(long_hold_ticks);
  assign bit_hold   = hold_of(bit_hold_ticks);
  assign short_hold = hold_of(short_hold_ticks);

  assign in_idle      = (phase == PH_IDLE);
  assign start_cmd    = accept && in_idle && cmd_valid && (op <= OP_READ);
  assign adv          = accept && !in_idle && (hold_count == '0);
  assign bit_inc      = bit_count + 4'd1;
  assign poll_expired = (poll_count >= ack_timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold_ticks   <= LONG_HOLD_RST;
      bit_hold_ticks    <= BIT_HOLD_RST;
      short_hold_ticks  <= SHORT_HOLD_RST;
      ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LONG_HOLD:   long_hold_ticks   <= cfg_data;
        CFG_BIT_HOLD:    bit_hold_ticks    <= cfg_data;
        CFG_SHORT_HOLD:  short_hold_ticks  <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase and hold counter
  always_comb begin
    phase_next      = phase;
    hold_count_next = hold_count;
    if (start_cmd) begin
      case (op)
        OP_START: begin phase_next = PH_ST_HIGH;  hold_count_next = long_hold;  end
        OP_STOP:  begin phase_next = PH_SP_LOW;   hold_count_next = long_hold;  end
        OP_WRITE: begin phase_next = PH_WR_SETUP; hold_count_next = bit_hold;   end
        OP_WAIT:  begin phase_next = PH_WA_REL;   hold_count_next = short_hold; end
        OP_READ:  begin phase_next = PH_RD_LOW;   hold_count_next = bit_hold;   end
        default: ;
      endcase
    end else if (accept && !in_idle && hold_count != '0) begin
      hold_count_next = hold_count - HW'(1);
    end else if (adv) begin
      case (phase)
        PH_ST_HIGH:  begin phase_next = PH_ST_LOW;  hold_count_next = long_hold; end
        PH_SP_LOW:   begin phase_next = PH_SP_HIGH; hold_count_next = long_hold; end
        PH_WR_SETUP: begin phase_next = PH_WR_HIGH; hold_count_next = bit_hold;  end
        PH_WR_HIGH:  begin phase_next = PH_WR_LOW;  hold_count_next = bit_hold;  end
        PH_WR_LOW: begin
          if (bit_inc[3]) begin
            phase_next      = PH_IDLE;
            hold_count_next = '0;
          end else begin
            phase_next      = PH_WR_SETUP;
            hold_count_next = bit_hold;
          end
        end
        PH_WA_REL: begin phase_next = PH_WA_POLL; hold_count_next = '0; end
        PH_WA_POLL: begin
          if (!sda_in) begin
            phase_next      = PH_IDLE;
            hold_count_next = '0;
          end else if (poll_expired) begin
            phase_next      = PH_SP_LOW;
            hold_count_next = long_hold;
          end
        end
        PH_RD_LOW: begin phase_next = PH_RD_HIGH; hold_count_next = short_hold; end
        PH_RD_HIGH: begin
          phase_next      = bit_inc[3] ? PH_AK_LOW : PH_RD_LOW;
          hold_count_next = bit_hold;
        end
        PH_AK_LOW: begin phase_next = PH_AK_HIGH; hold_count_next = bit_hold; end
        default: begin
          // stop/start tails, ack high, and any stray code finish here
          phase_next      = PH_IDLE;
          hold_count_next = '0;
        end
      endcase
    end
  end

  // Bus levels, shifter and flags
  always_comb begin
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    drive_reg_next  = drive_reg;
    shift_reg_next  = shift_reg;
    bit_count_next  = bit_count;
    poll_count_next = poll_count;
    ack_flag_next   = ack_flag;
    ack_choice_next = ack_choice;
    rx_reg_next     = rx_reg;
    if (start_cmd) begin
      case (op)
        OP_START: begin
          drive_reg_next = 1'b1; sda_reg_next = 1'b1; scl_reg_next = 1'b1;
        end
        OP_STOP: begin
          drive_reg_next = 1'b1; sda_reg_next = 1'b0; scl_reg_next = 1'b0;
        end
        OP_WRITE: begin
          shift_reg_next = tx_byte;
          bit_count_next = 4'd0;
          drive_reg_next = 1'b1; scl_reg_next = 1'b0; sda_reg_next = tx_byte[7];
        end
        OP_WAIT: begin
          drive_reg_next = 1'b0; sda_reg_next = 1'b1;
        end
        OP_READ: begin
          ack_choice_next = send_ack;
          shift_reg_next  = 8'd0;
          bit_count_next  = 4'd0;
          drive_reg_next  = 1'b0; sda_reg_next = 1'b1; scl_reg_next = 1'b0;
        end
        default: ;
      endcase
    end else if (adv) begin
      case (phase)
        PH_ST_HIGH:  sda_reg_next = 1'b0;
        PH_ST_LOW:   scl_reg_next = 1'b0;
        PH_SP_LOW: begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        PH_WR_SETUP: scl_reg_next = 1'b1;
        PH_WR_HIGH:  scl_reg_next = 1'b0;
        PH_WR_LOW: begin
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_count_next = bit_inc;
          if (!bit_inc[3]) begin
            drive_reg_next = 1'b1; scl_reg_next = 1'b0; sda_reg_next = shift_reg[6];
          end
        end
        PH_WA_REL: begin scl_reg_next = 1'b1; poll_count_next = 8'd0; end
        PH_WA_POLL: begin
          if (!sda_in) begin
            ack_flag_next = 1'b0;
            scl_reg_next  = 1'b0;
          end else if (poll_expired) begin
            // timed out: flag it and fall into a stop sequence
            ack_flag_next  = 1'b1;
            drive_reg_next = 1'b1; scl_reg_next = 1'b0; sda_reg_next = 1'b0;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        PH_RD_LOW: begin
          scl_reg_next   = 1'b1;
          shift_reg_next = {shift_reg[6:0], sda_in};
        end
        PH_RD_HIGH: begin
          bit_count_next = bit_inc;
          scl_reg_next   = 1'b0;
          if (bit_inc[3]) begin
            rx_reg_next    = shift_reg;
            drive_reg_next = 1'b1;
            sda_reg_next   = !ack_choice;
          end
        end
        PH_AK_LOW:  scl_reg_next = 1'b1;
        PH_AK_HIGH: scl_reg_next = 1'b0;
        default: ;
      endcase
    end
  end

  // Result for the item taken this cycle
  always_comb begin
    res.scl_level        = scl_reg_next;
    res.sda_level        = sda_reg_next;
    res.sda_drive_enable = drive_reg_next;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = !in_idle && (phase_next == PH_IDLE);
    res.rx_byte          = rx_reg_next;
    res.no_ack           = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      poll_count <= 8'd0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      drive_reg  <= 1'b1;
      ack_flag   <= 1'b0;
      ack_choice <= 1'b0;
      rx_reg     <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      poll_count <= poll_count_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      drive_reg  <= drive_reg_next;
      ack_flag   <= ack_flag_next;
      ack_choice <= ack_choice_next;
      rx_reg     <= rx_reg_next;
    end
  end

  // Output register plus one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= res;
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign scl_level        = out_data.scl_level;
  assign sda_level        = out_data.sda_level;
  assign sda_drive_enable = out_data.sda_drive_enable;
  assign busy_res         = out_data.busy_res;
  assign done_res         = out_data.done_res;
  assign rx_byte          = out_data.rx_byte;
  assign no_ack           = out_data.no_ack;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output slot empty");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (hold_count == '0))
    else $error("hold count left running in idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done result still marked busy");

  a_stalled_take_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && out_stall) |=> skid_valid)
    else $error("item taken under output stall was not parked");
`endif

endmodule

// ----- sim/i2c_master_bit_engine_tb.sv -----
// Self-checking testbench for the I2C master bit engine: per-tick prediction and scoreboard.
module i2c_master_bit_engine_tb;
  import i2cmbe_pkg::*;

  // Op values outside the command set; the engine must ignore them.
  localparam logic [2:0] OP_BAD_5 = 3'd5;
  localparam logic [2:0] OP_BAD_6 = 3'd6;
  localparam logic [2:0] OP_BAD_7 = 3'd7;

  // Target never pulls SDA low during wait-ack, so the engine must time out.
  localparam int NEVER_ACK = 1000;
  // Receiver hold-off that is long enough to fill both output slots.
  localparam int LONG_HOLD_OFF = 60;
  // Counted ticks per timing setting in the random part.
  localparam int TICKS_PER_SETTING = 30;
  localparam int NUM_SETTINGS = 8;

  // Bus state straight after reset, with and without a start just taken.
  localparam res_t RES_IDLE = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive_enable: 1'b1,
                                busy_res: 1'b0, done_res: 1'b0, rx_byte: 8'h00, no_ack: 1'b0};
  localparam res_t RES_START = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive_enable: 1'b1,
                                 busy_res: 1'b1, done_res: 1'b0, rx_byte: 8'h00, no_ack: 1'b0};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd_valid = 1'b0;
  logic [2:0] op = OP_START;
  logic [7:0] tx_byte = 8'h00;
  logic       send_ack = 1'b0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       no_ack;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_LONG_HOLD;
  logic [7:0] cfg_data = 8'h00;

  i2c_master_bit_engine DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd_valid        (cmd_valid),
    .op               (op),
    .tx_byte          (tx_byte),
    .send_ack         (send_ack),
    .sda_in           (sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .scl_level        (scl_level),
    .sda_level        (sda_level),
    .sda_drive_enable (sda_drive_enable),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .rx_byte          (rx_byte),
    .no_ack           (no_ack),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Engine predictor. Advanced once per accepted item, in acceptance order.
  // The stimulus side reads it too, so it knows what the engine is doing when
  // it picks the next SDA level (ack polls, read data).
  // ---------------------------------------------------------------------------
  logic [7:0] long_hold, bit_hold, short_hold, ack_limit;   // timing registers
  phase_t     ph;
  logic [7:0] hold_cnt;
  logic [3:0] bits_done;
  logic [7:0] shifter;
  logic [7:0] polls;
  logic       scl_q, sda_q, drv_q, nack_q, ack_sel, done_q;
  logic [7:0] rx_q;

  // Expected bus levels, one entry per accepted item, oldest first.
  res_t bus_levels_q[$];

  // Enter a step; a zero hold register still holds for one tick.
  function automatic void go(phase_t nxt, logic [7:0] ticks);
    ph = nxt;
    hold_cnt = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
  endfunction

  function automatic void end_cmd();
    ph = PH_IDLE;
    hold_cnt = 8'd0;
    done_q = 1'b1;
  endfunction

  // Put the next data bit on SDA with SCL low.
  function automatic void load_bit();
    drv_q = 1'b1;
    scl_q = 1'b0;
    sda_q = shifter[7];
    go(PH_WR_SETUP, bit_hold);
  endfunction

  function automatic res_t engine_tick(logic cmd_v, logic [2:0] cmd_op, logic [7:0] tx,
                                       logic ack, logic line);
    res_t r;
    done_q = 1'b0;
    if (ph == PH_IDLE) begin
      // commands are only taken while idle; unknown ops leave it idle
      if (cmd_v) begin
        case (cmd_op)
          OP_START: begin
            drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
            go(PH_ST_HIGH, long_hold);
          end
          OP_STOP: begin
            drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
            go(PH_SP_LOW, long_hold);
          end
          OP_WRITE: begin
            shifter = tx;
            bits_done = 4'd0;
            load_bit();
          end
          OP_WAIT: begin
            drv_q = 1'b0; sda_q = 1'b1;
            go(PH_WA_REL, short_hold);
          end
          OP_READ: begin
            ack_sel = ack;
            shifter = 8'h00;
            bits_done = 4'd0;
            drv_q = 1'b0; sda_q = 1'b1; scl_q = 1'b0;
            go(PH_RD_LOW, bit_hold);
          end
          default: ;
        endcase
      end
    end else if (hold_cnt != 8'd0) begin
      hold_cnt = hold_cnt - 8'd1;
    end else begin
      case (ph)
        PH_ST_HIGH: begin
          sda_q = 1'b0;
          go(PH_ST_LOW, long_hold);
        end
        PH_ST_LOW: begin
          scl_q = 1'b0;
          end_cmd();
        end
        PH_SP_LOW: begin
          scl_q = 1'b1; sda_q = 1'b1;
          go(PH_SP_HIGH, long_hold);
        end
        PH_SP_HIGH: end_cmd();
        PH_WR_SETUP: begin
          scl_q = 1'b1;
          go(PH_WR_HIGH, bit_hold);
        end
        PH_WR_HIGH: begin
          scl_q = 1'b0;
          go(PH_WR_LOW, bit_hold);
        end
        PH_WR_LOW: begin
          shifter = {shifter[6:0], 1'b0};
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) end_cmd();
          else load_bit();
        end
        PH_WA_REL: begin
          scl_q = 1'b1;
          polls = 8'd0;
          ph = PH_WA_POLL;
          hold_cnt = 8'd0;
        end
        PH_WA_POLL: begin
          if (!line) begin
            nack_q = 1'b0;
            scl_q = 1'b0;
            end_cmd();
          end else if (polls >= ack_limit) begin
            // timed out: flag no-ack and run a full stop
            nack_q = 1'b1;
            drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
            go(PH_SP_LOW, long_hold);
          end else begin
            polls = polls + 8'd1;
          end
        end
        PH_RD_LOW: begin
          scl_q = 1'b1;
          shifter = {shifter[6:0], line};
          go(PH_RD_HIGH, short_hold);
        end
        PH_RD_HIGH: begin
          bits_done = bits_done + 4'd1;
          scl_q = 1'b0;
          if (bits_done >= 4'd8) begin
            rx_q = shifter;
            drv_q = 1'b1;
            sda_q = ~ack_sel;
            go(PH_AK_LOW, bit_hold);
          end else begin
            go(PH_RD_LOW, bit_hold);
          end
        end
        PH_AK_LOW: begin
          scl_q = 1'b1;
          go(PH_AK_HIGH, bit_hold);
        end
        PH_AK_HIGH: begin
          scl_q = 1'b0;
          end_cmd();
        end
        default: end_cmd();
      endcase
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive_enable = drv_q;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = done_q;
    r.rx_byte = rx_q;
    r.no_ack = nack_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Target behavior on SDA, chosen per command by the stimulus.
  // ---------------------------------------------------------------------------
  int         cur_delay;          // high polls before the target acknowledges
  logic [7:0] cur_target;         // byte the target returns on a read
  bit         noise_on = 1'b0;    // occasionally break the well-formed SDA pattern

  function automatic logic line_level();
    if (noise_on && $urandom_range(0, 15) == 0) return 1'($urandom_range(0, 1));
    case (ph)
      PH_WA_POLL: return (int'(polls) >= cur_delay) ? 1'b0 : 1'b1;
      PH_RD_LOW:  return cur_target[3'd7 - bits_done[2:0]];
      default:    return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  bit calm = 1'b0;             // no idling on either side in the final setting
  bit hold_off_req = 1'b0;     // asks the receiver for one long hold-off
  bit failed = 1'b0;
  int engine_ticks = 0;        // items that start a command or land while busy

  // One item; sometimes waits out a random sender gap first, then waits for acceptance.
  task automatic drive_tick(logic cmd_v, logic [2:0] cmd_op, logic [7:0] tx, logic ack,
                            logic line, bit typed, res_t typed_res);
    res_t r;
    bit   counts;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd_valid <= cmd_v;
    op        <= cmd_op;
    tx_byte   <= tx;
    send_ack  <= ack;
    sda_in    <= line;
    do @(posedge clk); while (in_stall !== 1'b0);
    counts = (ph != PH_IDLE) || (cmd_v && cmd_op <= OP_READ);
    r = engine_tick(cmd_v, cmd_op, tx, ack, line);
    bus_levels_q.push_back(typed ? typed_res : r);
    if (counts) engine_ticks++;
  endtask

  // Issue a command item, then keep ticking until the engine is idle again.
  // Commands offered while busy are random and must be ignored.
  task automatic run_cmd(logic cmd_v, logic [2:0] cmd_op, logic [7:0] tx, logic ack,
                         bit typed, res_t typed_res);
    drive_tick(cmd_v, cmd_op, tx, ack, line_level(), typed, typed_res);
    while (ph != PH_IDLE)
      drive_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom),
                 1'($urandom_range(0, 1)), line_level(), 1'b0, '0);
  endtask

  // Command with fresh target behavior: mostly quick acks, sometimes none.
  task automatic bus_op(logic cmd_v, logic [2:0] cmd_op, logic [7:0] tx, logic ack);
    cur_delay = ($urandom_range(0, 3) == 0) ? NEVER_ACK : $urandom_range(0, 4);
    cur_target = 8'($urandom);
    run_cmd(cmd_v, cmd_op, tx, ack, 1'b0, '0);
  endtask

  // Sender pause until every expected item has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk);
  endtask

  // valid stays high across a run of writes; the caller lowers it
  task automatic cfg_put(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic load_timing(logic [7:0] lh, logic [7:0] bh, logic [7:0] sh, logic [7:0] tmo);
    cfg_put(CFG_LONG_HOLD, lh);
    cfg_put(CFG_BIT_HOLD, bh);
    cfg_put(CFG_SHORT_HOLD, sh);
    cfg_put(CFG_ACK_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
    long_hold  = lh;
    bit_hold   = bh;
    short_hold = sh;
    ack_limit  = tmo;
  endtask

  // ---------------------------------------------------------------------------
  // Directed commands under reset timing. Rows with a typed result are the
  // ones readable at a glance: idle after reset, ignored ops, first start tick.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic       cmd_v;
    logic [2:0] op;
    logic [7:0] tx;
    logic       ack;
    int         delay;
    logic [7:0] target;
    bit         typed;
    res_t       res;
  } dir_row_t;

  localparam int DIR_ROWS = 17;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, OP_START, 8'h00, 1'b0, 0,         8'h00, 1'b1, RES_IDLE},   // no command
    '{1'b1, OP_BAD_5, 8'hFF, 1'b1, 0,         8'h00, 1'b1, RES_IDLE},   // unknown ops
    '{1'b1, OP_BAD_6, 8'h00, 1'b0, 0,         8'h00, 1'b1, RES_IDLE},
    '{1'b1, OP_BAD_7, 8'hFF, 1'b1, 0,         8'h00, 1'b1, RES_IDLE},
    '{1'b1, OP_START, 8'h00, 1'b0, 0,         8'h00, 1'b1, RES_START},
    '{1'b1, OP_WRITE, 8'hFF, 1'b0, 0,         8'h00, 1'b0, '0},
    '{1'b1, OP_WAIT,  8'h00, 1'b0, 0,         8'h00, 1'b0, '0},         // ack on first poll
    '{1'b1, OP_WRITE, 8'h00, 1'b1, 0,         8'h00, 1'b0, '0},
    '{1'b1, OP_WAIT,  8'h00, 1'b0, 3,         8'h00, 1'b0, '0},         // late ack
    '{1'b1, OP_WRITE, 8'hA5, 1'b0, 0,         8'h00, 1'b0, '0},
    '{1'b1, OP_WAIT,  8'h00, 1'b0, NEVER_ACK, 8'h00, 1'b0, '0},         // timeout, auto stop
    '{1'b1, OP_START, 8'h00, 1'b0, 0,         8'h00, 1'b0, '0},
    '{1'b1, OP_READ,  8'h00, 1'b1, 0,         8'hFF, 1'b0, '0},
    '{1'b1, OP_READ,  8'hFF, 1'b1, 0,         8'h00, 1'b0, '0},
    '{1'b1, OP_READ,  8'h00, 1'b0, 0,         8'h5A, 1'b0, '0},         // NACK after read
    '{1'b1, OP_STOP,  8'h00, 1'b0, 0,         8'h00, 1'b0, '0},
    '{1'b1, OP_WRITE, 8'h80, 1'b0, 0,         8'h00, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request so the
  // skid stage fills and in_stall must rise.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = LONG_HOLD_OFF;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic cmp(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (bus_levels_q.size() == 0) begin
        $error("result with no item outstanding");
        failed = 1'b1;
      end else begin
        want = bus_levels_q.pop_front();
        cmp("scl_level", 8'(want.scl_level), 8'(scl_level));
        cmp("sda_level", 8'(want.sda_level), 8'(sda_level));
        cmp("sda_drive_enable", 8'(want.sda_drive_enable), 8'(sda_drive_enable));
        cmp("busy_res", 8'(want.busy_res), 8'(busy_res));
        cmp("done_res", 8'(want.done_res), 8'(done_res));
        cmp("rx_byte", want.rx_byte, rx_byte);
        cmp("no_ack", 8'(want.no_ack), 8'(no_ack));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] lh, bh, sh, tmo;
    logic [7:0] addr;
    int         first;
    int         n;
    bit         rd;
    bit         hold_asked;

    // predictor reset state, timing registers at their defaults
    long_hold = LONG_HOLD_RST;
    bit_hold = BIT_HOLD_RST;
    short_hold = SHORT_HOLD_RST;
    ack_limit = ACK_TIMEOUT_RST;
    ph = PH_IDLE;
    hold_cnt = 8'd0; bits_done = 4'd0; shifter = 8'h00; polls = 8'd0;
    scl_q = 1'b1; sda_q = 1'b1; drv_q = 1'b1; nack_q = 1'b0;
    ack_sel = 1'b0; rx_q = 8'h00; done_q = 1'b0;
    hold_asked = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      cur_delay = dir_tab[k].delay;
      cur_target = dir_tab[k].target;
      run_cmd(dir_tab[k].cmd_v, dir_tab[k].op, dir_tab[k].tx, dir_tab[k].ack,
              dir_tab[k].typed, dir_tab[k].res);
    end

    // Random part, one timing setting at a time: all zeros (zero hold and
    // zero timeout), all ones at the top, all ones, several small random
    // settings, and the reset values last with no idling at all.
    noise_on = 1'b1;
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p == 0) begin
        lh = 8'd0; bh = 8'd0; sh = 8'd0; tmo = 8'd0;
      end else if (p == 1) begin
        lh = 8'd255; bh = 8'd255; sh = 8'd255; tmo = 8'd255;
      end else if (p == 2) begin
        lh = 8'd1; bh = 8'd1; sh = 8'd1; tmo = 8'd1;
      end else if (p == NUM_SETTINGS - 1) begin
        lh = LONG_HOLD_RST; bh = BIT_HOLD_RST; sh = SHORT_HOLD_RST; tmo = ACK_TIMEOUT_RST;
      end else begin
        lh = 8'($urandom_range(0, 6));
        bh = 8'($urandom_range(0, 5));
        sh = 8'($urandom_range(0, 4));
        tmo = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 12));
      end
      wait_drained();
      load_timing(lh, bh, sh, tmo);
      calm = (p == NUM_SETTINGS - 1);
      first = engine_ticks;
      while (engine_ticks - first < TICKS_PER_SETTING) begin
        if (p == 3 && !hold_asked) begin
          hold_off_req = 1'b1;
          hold_asked = 1'b1;
        end
        if (p == 1) begin
          // slow setting: a single start already runs for hundreds of ticks
          bus_op(1'b1, OP_START, 8'($urandom), 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 5) == 0) begin
          // lone command with random fields
          bus_op(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom),
                 1'($urandom_range(0, 1)));
        end else begin
          // framed transfer: start, address, ack, data bytes, stop
          n = $urandom_range(1, 2);
          rd = 1'($urandom_range(0, 1));
          addr = 8'($urandom);
          addr[0] = rd;
          bus_op(1'b1, OP_START, 8'($urandom), 1'($urandom_range(0, 1)));
          bus_op(1'b1, OP_WRITE, addr, 1'($urandom_range(0, 1)));
          bus_op(1'b1, OP_WAIT, 8'($urandom), 1'($urandom_range(0, 1)));
          for (int i = 0; i < n; i++) begin
            if (rd) begin
              bus_op(1'b1, OP_READ, 8'($urandom), (i != n - 1));
            end else begin
              bus_op(1'b1, OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
              bus_op(1'b1, OP_WAIT, 8'($urandom), 1'($urandom_range(0, 1)));
            end
          end
          bus_op(1'b1, OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        // idle ticks between transfers
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3))
            bus_op(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
